// ===== hw/rtl/ssconv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssconv_pkg: shared types and constants of the same-size 3x3 convolution
// Sizes of the line store, fixed-point formats, configuration register
// indexes, command codes and the word types of both channels.
// ----------------------------------------------------------------------------
package ssconv_pkg;

  // Frame and kernel geometry.
  localparam int MAX_WIDTH   = 1024;
  localparam int KERNEL_SIZE = 3;
  localparam int HALF_K      = KERNEL_SIZE / 2;
  localparam int NTAPS       = KERNEL_SIZE * KERNEL_SIZE;

  // Line store: one bank per row slot, rows live in slot (row mod ROW_SLOTS).
  localparam int ROW_SLOTS  = 4;
  localparam int SLOT_W     = $clog2(ROW_SLOTS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int BANK_DEPTH = 1 << COL_W;
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);

  // Fixed-point formats.
  localparam int PIX_W  = 16;
  localparam int COEF_W = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 40;

  // Configuration port.
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int IW_W           = 11;
  localparam int HGT_W          = 16;
  localparam int COEF_PER_GROUP = CFG_W / COEF_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_GROUP_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_GROUP_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST    = 3'd4;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Output queue and the arithmetic pipeline behind the line store.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int MAC_LAT   = 3;
  localparam int FLY_W     = $clog2(MAC_LAT + 1);
  localparam int OCC_W     = $clog2(OUT_DEPTH + MAC_LAT + 1);

  typedef struct packed {
    logic                    command;
    logic signed [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_value;
    logic                    frame_last;
  } out_t;

  // Window read issued to the line store, aligned with the read data.
  typedef struct packed {
    logic                               valid;
    logic                               last;
    logic                               first_col;
    logic [KERNEL_SIZE-1:0][SLOT_W-1:0] bank;
    logic [KERNEL_SIZE-1:0]             row_ok;
    logic [1:0]                         col_ok;
    logic [KERNEL_SIZE-1:0][1:0]        fwd;
    logic [PIX_W-1:0]                   fwd_pix;
  } issue_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ssconv_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssconv_ram: generic synchronous RAM
// One write port and two read ports sharing one read enable; read data is
// registered and returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module ssconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssconv_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssconv_ctrl: raster position tracking and line store access
// Keeps the input and output positions, writes pushed pixels into the line
// store, decides when the next output is ready and issues its window reads.
// ----------------------------------------------------------------------------
module ssconv_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  ssconv_pkg::in_t                     in_data_i,
  input  logic [ssconv_pkg::IW_W-1:0]         image_width_i,
  input  logic [ssconv_pkg::HGT_W-1:0]        image_height_i,
  output logic [ssconv_pkg::ROW_SLOTS-1:0]    wr_en_o,
  output logic [ssconv_pkg::COL_W-1:0]        wr_addr_o,
  output logic [ssconv_pkg::PIX_W-1:0]        wr_data_o,
  output logic                                rd_en_o,
  output logic [ssconv_pkg::COL_W-1:0]        rd_addr_a_o,
  output logic [ssconv_pkg::COL_W-1:0]        rd_addr_b_o,
  output ssconv_pkg::issue_t                  issue_o
);
  import ssconv_pkg::*;

  logic [WID_W-1:0] wid;
  logic [HGT_W-1:0] hgt;
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HGT_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [COL_W-1:0] in_col_n, col_b;
  logic [HGT_W-1:0] in_row_n;
  logic             do_write, rdy, issue, last, out_wrap;
  issue_t           issue_d, issue_q;

  // A width of zero acts as one, a width beyond the store as its maximum.
  always_comb begin
    if (image_width_i == '0) begin
      wid = WID_W'(1);
    end else if (32'(image_width_i) > MAX_WIDTH) begin
      wid = WID_W'(MAX_WIDTH);
    end else begin
      wid = WID_W'(image_width_i);
    end
    hgt = (image_height_i == '0) ? HGT_W'(1) : image_height_i;
  end

  assign do_write = take_i && (in_data_i.command == CMD_PUSH) && (in_row_q < hgt);
  assign col_b    = out_col_q + COL_W'(1);

  // Input position after this word's pixel has gone in.
  always_comb begin
    in_col_n = in_col_q;
    in_row_n = in_row_q;
    if (do_write) begin
      if (32'(in_col_q) + 1 >= 32'(wid)) begin
        in_col_n = '0;
        in_row_n = in_row_q + HGT_W'(1);
      end else begin
        in_col_n = in_col_q + COL_W'(1);
      end
    end
  end

  // The next output is ready once its lower right neighbor is in, once
  // the row below is complete, or once the whole frame is in.
  assign rdy = (in_row_n >= hgt)
            || (32'(in_row_n) > 32'(out_row_q) + HALF_K)
            || ((32'(in_row_n) == 32'(out_row_q) + HALF_K)
                && (32'(in_col_n) > 32'(out_col_q) + HALF_K));
  assign issue    = take_i && rdy;
  assign out_wrap = 32'(out_col_q) + 1 >= 32'(wid);
  assign last     = out_wrap && (32'(out_row_q) + 1 >= 32'(hgt));

  always_comb begin
    in_col_d  = in_col_n;
    in_row_d  = in_row_n;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (issue) begin
      if (out_wrap) begin
        out_col_d = '0;
        if (last) begin
          out_row_d = '0;
          in_row_d  = '0;
          in_col_d  = '0;
        end else begin
          out_row_d = out_row_q + HGT_W'(1);
        end
      end else begin
        out_col_d = out_col_q + COL_W'(1);
      end
    end
  end

  // Window rows r-1, r and r+1 sit in three distinct banks; both columns c
  // and c+1 are read from every bank. A read of the entry written in the
  // same cycle takes the incoming pixel instead.
  always_comb begin
    issue_d           = '0;
    issue_d.valid     = issue;
    issue_d.last      = last;
    issue_d.first_col = (out_col_q == '0);
    issue_d.col_ok[0] = 32'(out_col_q) < 32'(wid);
    issue_d.col_ok[1] = 32'(out_col_q) + 1 < 32'(wid);
    issue_d.fwd_pix   = in_data_i.pixel;
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      issue_d.bank[k]   = SLOT_W'(32'(out_row_q[SLOT_W-1:0]) + k + ROW_SLOTS - HALF_K);
      issue_d.row_ok[k] = (32'(out_row_q) + k >= HALF_K)
                       && (32'(out_row_q) + k - HALF_K < 32'(hgt));
      issue_d.fwd[k][0] = do_write && (in_row_q[SLOT_W-1:0] == issue_d.bank[k])
                       && (in_col_q == out_col_q);
      issue_d.fwd[k][1] = do_write && (in_row_q[SLOT_W-1:0] == issue_d.bank[k])
                       && (in_col_q == col_b);
    end
  end

  always_comb begin
    for (int b = 0; b < ROW_SLOTS; b++) begin
      wr_en_o[b] = do_write && (in_row_q[SLOT_W-1:0] == SLOT_W'(b));
    end
  end

  assign wr_addr_o   = in_col_q;
  assign wr_data_o   = in_data_i.pixel;
  assign rd_en_o     = issue;
  assign rd_addr_a_o = out_col_q;
  assign rd_addr_b_o = col_b;
  assign issue_o     = issue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      issue_q   <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      issue_q   <= issue_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssconv_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssconv_mac: window assembly and multiply-accumulate pipeline
// Builds the 3x3 window from the line store read data, multiplies it by
// the kernel and sums the nine products over two adder stages.
// ----------------------------------------------------------------------------
module ssconv_mac (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  ssconv_pkg::issue_t                                 issue_i,
  input  logic [ssconv_pkg::ROW_SLOTS-1:0][ssconv_pkg::PIX_W-1:0] rd_a_i,
  input  logic [ssconv_pkg::ROW_SLOTS-1:0][ssconv_pkg::PIX_W-1:0] rd_b_i,
  input  logic [ssconv_pkg::NTAPS-1:0][ssconv_pkg::COEF_W-1:0]    coef_i,
  output logic                                               res_valid_o,
  output ssconv_pkg::out_t                                   res_o,
  output logic [ssconv_pkg::FLY_W-1:0]                       inflight_o
);
  import ssconv_pkg::*;

  logic [PIX_W-1:0]              cen_q [KERNEL_SIZE];
  logic [KERNEL_SIZE-1:0][PIX_W-1:0] pix_a, pix_b;
  logic [NTAPS-1:0][PIX_W-1:0]   win;
  logic signed [PROD_W-1:0]      prod_d [NTAPS];
  logic signed [PROD_W-1:0]      prod_q [NTAPS];
  logic signed [SUM_W-1:0]       part_d [KERNEL_SIZE];
  logic signed [SUM_W-1:0]       part_q [KERNEL_SIZE];
  logic                          v2_q, v3_q, last2_q, last3_q;

  // The left column is the previous output's center column, or zero
  // padding at the start of a row.
  always_comb begin
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      pix_a[k] = issue_i.fwd[k][0] ? issue_i.fwd_pix : rd_a_i[issue_i.bank[k]];
      pix_b[k] = issue_i.fwd[k][1] ? issue_i.fwd_pix : rd_b_i[issue_i.bank[k]];
      if (!(issue_i.row_ok[k] && issue_i.col_ok[0])) begin
        pix_a[k] = '0;
      end
      if (!(issue_i.row_ok[k] && issue_i.col_ok[1])) begin
        pix_b[k] = '0;
      end
      win[k*KERNEL_SIZE]     = issue_i.first_col ? '0 : cen_q[k];
      win[k*KERNEL_SIZE + 1] = pix_a[k];
      win[k*KERNEL_SIZE + 2] = pix_b[k];
    end
    for (int n = 0; n < NTAPS; n++) begin
      prod_d[n] = $signed(win[n]) * $signed(coef_i[n]);
    end
  end

  always_comb begin
    for (int g = 0; g < KERNEL_SIZE; g++) begin
      part_d[g] = SUM_W'(prod_q[g*KERNEL_SIZE]) + SUM_W'(prod_q[g*KERNEL_SIZE + 1])
                + SUM_W'(prod_q[g*KERNEL_SIZE + 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        cen_q[k] <= pix_a[k];
      end
    end
    prod_q  <= prod_d;
    last2_q <= issue_i.last;
    part_q  <= part_d;
    last3_q <= last2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= issue_i.valid;
      v3_q <= v2_q;
    end
  end

  assign res_valid_o      = v3_q;
  assign res_o.conv_value = part_q[0] + part_q[1] + part_q[2];
  assign res_o.frame_last = last3_q;
  assign inflight_o       = FLY_W'(issue_i.valid) + FLY_W'(v2_q) + FLY_W'(v3_q);

endmodule
`default_nettype wire

// ===== hw/rtl/ssconv_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssconv_fifo: output word queue
// Small register queue that decouples the arithmetic pipeline from the
// receiver; its fill level feeds the input credit check.
// ----------------------------------------------------------------------------
module ssconv_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  ssconv_pkg::out_t                push_data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output ssconv_pkg::out_t                data_o,
  output logic [ssconv_pkg::OUT_CNT_W-1:0] count_o
);
  import ssconv_pkg::*;

  out_t                 mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] count_q, count_d;

  assign count_d = count_q + OUT_CNT_W'(push_i) - OUT_CNT_W'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/same_size_2d_convolution.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// same_size_2d_convolution: streaming 3x3 zero-padded correlation
// Takes pixels in raster order and returns a same-size image of window
// sums, with a flush command to drain the outputs owed at frame end.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel carries one word per handshake: a push command with a
// signed Q8.8 pixel, or a flush command whose pixel is ignored. The output
// channel returns signed Q18.22 window sums in raster order, with frame_last
// set on the final pixel of the frame. Outputs trail the input by about one
// row and one pixel, so a frame is completed with flush words.
// Throughput is one word per cycle while in_ready_o is high. Each word costs
// at most one line store access: the bank of the pixel's row takes one write
// and every bank two reads, so a pushed pixel and the two new window columns
// of the next output share a single cycle. A result passes the window read,
// product and partial sum registers, then enters the output queue on the way out.
// When the receiver stalls, results collect in an eight-word output queue;
// in_ready_o drops once the queue plus the three pipeline stages could fill
// it, and rises again as soon as the receiver takes words.
// Reset clears the raster counters and the pipeline, sets the width to 1024
// and the height to 1, and zeroes the coefficients. The line store is not
// cleared; every entry a window reads has been written earlier in the frame.
// Configuration must be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module same_size_2d_convolution (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ssconv_pkg::in_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ssconv_pkg::out_t                    out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ssconv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssconv_pkg::CFG_W-1:0]        cfg_data_i
);
  import ssconv_pkg::*;

  // Configuration registers.
  logic [IW_W-1:0]   width_q;
  logic [HGT_W-1:0]  height_q;
  logic [CFG_W-1:0]  coef_a_q, coef_b_q;
  logic [COEF_W-1:0] coef_last_q;
  logic [NTAPS-1:0][COEF_W-1:0] coef;

  // Line store traffic.
  logic [ROW_SLOTS-1:0]             wr_en;
  logic [COL_W-1:0]                 wr_addr, rd_addr_a, rd_addr_b;
  logic [PIX_W-1:0]                 wr_data;
  logic                             rd_en;
  logic [ROW_SLOTS-1:0][PIX_W-1:0]  rd_a, rd_b;
  issue_t                           issue;

  // Result path and credit.
  logic                 take, res_valid, fifo_pop;
  out_t                 res;
  logic [FLY_W-1:0]     inflight;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic [OCC_W-1:0]     occ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= IW_W'(1024);
      height_q    <= HGT_W'(1);
      coef_a_q    <= '0;
      coef_b_q    <= '0;
      coef_last_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q     <= cfg_data_i[IW_W-1:0];
        CFG_IMAGE_HEIGHT: height_q    <= cfg_data_i[HGT_W-1:0];
        CFG_COEF_GROUP_A: coef_a_q    <= cfg_data_i;
        CFG_COEF_GROUP_B: coef_b_q    <= cfg_data_i;
        CFG_COEF_LAST:    coef_last_q <= cfg_data_i[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Kernel coefficients in row-major order: the two 64-bit groups hold four
  // each, lowest coefficient in the lowest half-word, then the last one.
  always_comb begin
    for (int n = 0; n < NTAPS; n++) begin
      if (n < COEF_PER_GROUP) begin
        coef[n] = coef_a_q[n*COEF_W +: COEF_W];
      end else if (n < 2 * COEF_PER_GROUP) begin
        coef[n] = coef_b_q[(n - COEF_PER_GROUP)*COEF_W +: COEF_W];
      end else begin
        coef[n] = coef_last_q;
      end
    end
  end

  // A word is only taken when its possible result is sure to find room in
  // the output queue, counting everything still in the pipeline.
  assign occ        = OCC_W'(fifo_count) + OCC_W'(inflight);
  assign in_ready_o = (occ < OCC_W'(OUT_DEPTH));
  assign take       = in_valid_i && in_ready_o;
  assign fifo_pop   = out_valid_o && out_ready_i;

  ssconv_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .in_data_i      (in_data_i),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_a_o    (rd_addr_a),
    .rd_addr_b_o    (rd_addr_b),
    .issue_o        (issue)
  );

  // One bank per row slot, so three window rows are read in parallel.
  for (genvar b = 0; b < ROW_SLOTS; b++) begin : g_bank
    ssconv_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i     (clk_i),
      .we_i      (wr_en[b]),
      .waddr_i   (wr_addr),
      .wdata_i   (wr_data),
      .re_i      (rd_en),
      .raddr_a_i (rd_addr_a),
      .raddr_b_i (rd_addr_b),
      .rdata_a_o (rd_a[b]),
      .rdata_b_o (rd_b[b])
    );
  end

  ssconv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .coef_i      (coef),
    .res_valid_o (res_valid),
    .res_o       (res),
    .inflight_o  (inflight)
  );

  ssconv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (fifo_pop),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o),
    .count_o     (fifo_count)
  );

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !fifo_pop) |-> (fifo_count < OUT_CNT_W'(OUT_DEPTH)))
    else $error("output queue written while full");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_W'(OUT_DEPTH))
    else $error("queued plus in-flight results exceed the queue depth");

  a_issue_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue.valid |-> $past(take))
    else $error("window read issued without an accepted word");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream test of the same-size 3x3 convolution
// Sends push and flush words in raster order and checks every window sum and
// frame-end flag against a cycle-free model of the line stores and counters.
// A short scripted part covers reset values, extreme coefficients and pixels
// and the clamped width and height cases. Random frames then follow under
// four idling patterns, plus one long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
  import ssconv_pkg::*;

  // Cycles allowed after the last owed result before a register write or the
  // end of the run.
  localparam int SLACK_CYCLES   = 16;
  // The longest legal quiet stretch is the long receiver hold below.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASE_WORDS    = 190;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WORD,
    ROW_FILL
  } row_kind_e;

  // One line of the scripted part. A word row may carry a result that is
  // written down by hand; all other words are checked against the model.
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
    in_t                  word;
    logic                 known;
    logic                 known_has;
    out_t                 known_res;
  } script_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  same_size_2d_convolution u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the registers, as they stand after reset.
  logic [IW_W-1:0]   cfg_width     = 11'd1024;
  logic [HGT_W-1:0]  cfg_height    = 16'd1;
  logic [CFG_W-1:0]  cfg_coef_a    = '0;
  logic [CFG_W-1:0]  cfg_coef_b    = '0;
  logic [COEF_W-1:0] cfg_coef_last = '0;

  // Model of the four row slots and of the input and output raster counters.
  logic [PIX_W-1:0] line_copy [ROW_SLOTS*MAX_WIDTH];
  int unsigned      px_row  = 0;
  int unsigned      px_col  = 0;
  int unsigned      win_row = 0;
  int unsigned      win_col = 0;
  bit               frame_done = 1'b0;

  out_t owed_sums [$];
  int   bad_words   = 0;
  int   phase_words = 0;
  int   gap_pct     = 0;
  int   stall_pct   = 0;
  int   hold_asks   = 0;

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  // Coefficients are numbered row-major over the 3x3 kernel.
  function automatic logic signed [COEF_W-1:0] coef_of(int n);
    if (n < COEF_PER_GROUP) return cfg_coef_a[COEF_W*n +: COEF_W];
    if (n < 2*COEF_PER_GROUP) return cfg_coef_b[COEF_W*(n-COEF_PER_GROUP) +: COEF_W];
    return cfg_coef_last;
  endfunction

  // Advances the model by one accepted word and tells whether it yields a
  // window sum. A push stores its pixel only while the frame is still coming
  // in; after that it behaves as a flush. The next output is due once the
  // pixel below and right of its center has arrived, its lower row is
  // complete, or the whole frame is in.
  task automatic conv_predict(input in_t w, output bit has, output out_t res);
    int unsigned wid;
    int unsigned hgt;
    int unsigned need;
    int unsigned col;
    int          k;
    int          l;
    int          y;
    int          x;
    longint      acc;
    logic [PIX_W-1:0] pix;
    bit          last;
    has = 1'b0;
    res = '0;
    wid = eff_width();
    hgt = eff_height();
    if (w.command == CMD_PUSH && px_row < hgt) begin
      col = (px_col < MAX_WIDTH) ? px_col : MAX_WIDTH - 1;
      line_copy[(px_row % ROW_SLOTS) * MAX_WIDTH + col] = w.pixel;
      if (px_col + 1 >= wid) begin
        px_col = 0;
        px_row++;
      end else begin
        px_col++;
      end
    end
    need = win_row + HALF_K;
    if (!(px_row >= hgt || px_row > need || (px_row == need && px_col > win_col + HALF_K)))
      return;
    // Neighbors outside the frame count as zero; the kernel is not flipped.
    acc = 0;
    for (k = 0; k < KERNEL_SIZE; k++) begin
      for (l = 0; l < KERNEL_SIZE; l++) begin
        y = int'(win_row) + k - HALF_K;
        x = int'(win_col) + l - HALF_K;
        pix = '0;
        if (y >= 0 && x >= 0 && y < int'(hgt) && x < int'(wid))
          pix = line_copy[(y % ROW_SLOTS) * MAX_WIDTH + x];
        acc += longint'($signed(pix)) * longint'(coef_of(k * KERNEL_SIZE + l));
      end
    end
    last = (win_col + 1 >= wid) && (win_row + 1 >= hgt);
    if (win_col + 1 >= wid) begin
      win_col = 0;
      win_row++;
      // The final output of a frame rewinds all four counters.
      if (win_row >= hgt) begin
        win_row = 0;
        px_row  = 0;
        px_col  = 0;
      end
    end else begin
      win_col++;
    end
    res.conv_value = SUM_W'(acc);
    res.frame_last = last;
    has = 1'b1;
    if (last) frame_done = 1'b1;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Mostly pushes while the frame is coming in, with a few early flushes as
  // noise; once it is all in, pushes and flushes both drain the owed outputs.
  function automatic in_t next_stream_word();
    in_t w;
    w.pixel = rand_pixel();
    if (px_row < eff_height())
      w.command = ($urandom_range(99) < 92) ? CMD_PUSH : CMD_FLUSH;
    else
      w.command = $urandom_range(1) ? CMD_PUSH : CMD_FLUSH;
    return w;
  endfunction

  // Offers one word, with random idle cycles ahead of it, and records what it
  // should produce once the block takes it. The valid stays high on return so
  // that a word sent in the same step follows back to back.
  task automatic send_word(input in_t w, input bit known, input bit known_has,
                           input out_t known_res);
    bit   has;
    out_t res;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    conv_predict(w, has, res);
    if (known) begin
      has = known_has;
      res = known_res;
    end
    if (has) owed_sums.push_back(res);
    phase_words++;
  endtask

  // Stops sending and lets every owed result and anything still in the
  // pipeline come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (owed_sums.size() != 0) @(posedge clk_i);
    repeat (SLACK_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      CFG_IMAGE_WIDTH:  cfg_width     = value[IW_W-1:0];
      CFG_IMAGE_HEIGHT: cfg_height    = value[HGT_W-1:0];
      CFG_COEF_GROUP_A: cfg_coef_a    = value;
      CFG_COEF_GROUP_B: cfg_coef_b    = value;
      CFG_COEF_LAST:    cfg_coef_last = value[COEF_W-1:0];
      default: ;
    endcase
  endtask

  // Sends random words until the frame in progress has given its last output.
  task automatic run_frame();
    frame_done = 1'b0;
    do send_word(next_stream_word(), 1'b0, 1'b0, '0); while (!frame_done);
  endtask

  function automatic logic [CFG_W-1:0] rand_coefs();
    case ($urandom_range(19))
      0, 1, 2: return {COEF_PER_GROUP{16'h8000}};
      3, 4:    return {COEF_PER_GROUP{16'h7fff}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Frames are kept small so that many of them fit in a phase; a zero width
  // or height shows up now and then and must act as one.
  task automatic pick_frame_setup();
    int r;
    logic [CFG_W-1:0] wid;
    logic [CFG_W-1:0] hgt;
    r = $urandom_range(99);
    wid = (r < 5) ? 0 : (r < 65) ? $urandom_range(6, 1) : $urandom_range(24, 7);
    r = $urandom_range(99);
    hgt = (r < 5) ? 0 : (r < 80) ? $urandom_range(5, 1) : $urandom_range(12, 6);
    write_reg(CFG_IMAGE_WIDTH, wid);
    write_reg(CFG_IMAGE_HEIGHT, hgt);
    if ($urandom_range(1)) write_reg(CFG_COEF_GROUP_A, rand_coefs());
    if ($urandom_range(1)) write_reg(CFG_COEF_GROUP_B, rand_coefs());
    if ($urandom_range(1)) write_reg(CFG_COEF_LAST, {48'd0, rand_coefs()[COEF_W-1:0]});
  endtask

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    script_row_t row;
    row = '0;
    row.kind  = ROW_CFG;
    row.index = index;
    row.value = value;
    return row;
  endfunction

  function automatic script_row_t word_row(logic cmd, logic [PIX_W-1:0] pix);
    script_row_t row;
    row = '0;
    row.kind          = ROW_WORD;
    row.word.command  = cmd;
    row.word.pixel    = pix;
    return row;
  endfunction

  function automatic script_row_t known_row(logic cmd, logic [PIX_W-1:0] pix, logic has,
                                            logic [SUM_W-1:0] sum, logic last);
    script_row_t row;
    row = word_row(cmd, pix);
    row.known                = 1'b1;
    row.known_has            = has;
    row.known_res.conv_value = sum;
    row.known_res.frame_last = last;
    return row;
  endfunction

  function automatic script_row_t fill_row();
    script_row_t row;
    row = '0;
    row.kind = ROW_FILL;
    return row;
  endfunction

  task automatic check_word(input out_t got);
    out_t want;
    if (owed_sums.size() == 0) begin
      bad_words++;
      if (bad_words <= MAX_REPORTS)
        $display("unexpected result: conv_value %h frame_last %b",
                 got.conv_value, got.frame_last);
      return;
    end
    want = owed_sums.pop_front();
    if (got.conv_value !== want.conv_value || got.frame_last !== want.frame_last) begin
      bad_words++;
      if (bad_words <= MAX_REPORTS)
        $display("mismatch: conv_value %h (want %h) frame_last %b (want %b)",
                 got.conv_value, want.conv_value, got.frame_last, want.frame_last);
    end
  endtask

  // Receiver: checks each accepted result, then decides the next ready.
  // A long hold is requested by bumping hold_asks and is timed here.
  int hold_served = 0;
  int hold_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_word(out_data_o);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  script_row_t script [$];
  int          phase_gap   [4] = '{0, 76, 0, 19};
  int          phase_stall [4] = '{0, 0, 76, 19};

  initial begin
    // The scripted part. With all coefficients at the most negative value and
    // every pixel at the most negative value, each product is 2^30, so a sum
    // is 2^30 times the number of neighbors inside the 3x3 frame.
    script = '{
      // Reset values: 1024 wide, one row, zero kernel. Nothing can come out
      // before the whole row is in, so the frame is finished at random.
      known_row(CMD_PUSH, 16'h7fff, 1'b0, '0, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b0, '0, 1'b0),
      known_row(CMD_PUSH, 16'h1234, 1'b0, '0, 1'b0),
      fill_row(),
      reg_row(CFG_IMAGE_WIDTH, 64'd3),
      reg_row(CFG_IMAGE_HEIGHT, 64'd3),
      reg_row(CFG_COEF_GROUP_A, 64'h8000_8000_8000_8000),
      reg_row(CFG_COEF_GROUP_B, 64'h8000_8000_8000_8000),
      reg_row(CFG_COEF_LAST, 64'h8000),
      // A flush before anything is owed produces nothing.
      known_row(CMD_FLUSH, 16'h5a5a, 1'b0, '0, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b0, '0, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b0, '0, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b0, '0, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b0, '0, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b1, 40'h01_0000_0000, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b1, 40'h01_8000_0000, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b1, 40'h01_0000_0000, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b1, 40'h01_8000_0000, 1'b0),
      known_row(CMD_PUSH, 16'h8000, 1'b1, 40'h02_4000_0000, 1'b0),
      // The frame is all in: this pixel is dropped and the push drains.
      known_row(CMD_PUSH, 16'h7fff, 1'b1, 40'h01_8000_0000, 1'b0),
      known_row(CMD_FLUSH, 16'h0000, 1'b1, 40'h01_0000_0000, 1'b0),
      known_row(CMD_FLUSH, 16'hffff, 1'b1, 40'h01_8000_0000, 1'b0),
      known_row(CMD_FLUSH, 16'h0000, 1'b1, 40'h01_0000_0000, 1'b1),
      // Zero width and height act as a single pixel frame.
      reg_row(CFG_IMAGE_WIDTH, 64'd0),
      reg_row(CFG_IMAGE_HEIGHT, 64'd0),
      reg_row(CFG_COEF_GROUP_A, 64'h7fff_0001_c000_4000),
      reg_row(CFG_COEF_GROUP_B, 64'h2000_8001_ffff_7fff),
      reg_row(CFG_COEF_LAST, 64'h7fff),
      word_row(CMD_PUSH, 16'h7fff),
      // A width beyond the line store acts as the full 1024.
      reg_row(CFG_IMAGE_WIDTH, 64'd2047),
      reg_row(CFG_IMAGE_HEIGHT, 64'd1),
      fill_row(),
      // Tallest frame: three rows go in, then the height is cut to three
      // while idle, which completes the frame.
      reg_row(CFG_IMAGE_WIDTH, 64'd2),
      reg_row(CFG_IMAGE_HEIGHT, 64'd65535),
      word_row(CMD_PUSH, 16'h0100),
      word_row(CMD_PUSH, 16'hff00),
      word_row(CMD_PUSH, 16'h8000),
      word_row(CMD_PUSH, 16'h7fff),
      word_row(CMD_PUSH, 16'h0001),
      word_row(CMD_PUSH, 16'hfffe),
      reg_row(CFG_IMAGE_HEIGHT, 64'd3),
      fill_row()
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG:  write_reg(script[i].index, script[i].value);
        ROW_WORD: send_word(script[i].word, script[i].known, script[i].known_has,
                            script[i].known_res);
        default:  run_frame();
      endcase
    end

    // Long receiver hold while a wide frame keeps coming: the output queue
    // fills and the block has to stall its input.
    write_reg(CFG_IMAGE_WIDTH, 64'd12);
    write_reg(CFG_IMAGE_HEIGHT, 64'd4);
    hold_asks++;
    run_frame();

    // Random frames under each idling pattern. Every register write waits
    // until the previous frame has fully drained.
    for (int p = 0; p < 4; p++) begin
      gap_pct     = phase_gap[p];
      stall_pct   = phase_stall[p];
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        pick_frame_setup();
        run_frame();
      end
    end

    wait_idle();
    if (bad_words == 0 && owed_sums.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
